@@ src/g6e_pkg.sv @@
package g6e_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAPH_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_BASE = 1'b1;

    localparam logic [6:0] ORDER_RESET = 7'd64;

    // item kinds
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // field and datapath widths (fixed by the 7-bit vertex numbers)
    localparam int unsigned V_W    = 7;
    localparam int unsigned WORD_W = 6;
    localparam int unsigned PROD_W = 14;  // v*(v-1), v < 128
    localparam int unsigned SUM_W  = 13;  // bit index or padded bit count
    localparam int unsigned Q_W    = 11;  // SUM / 6

    // graph6 character constants
    localparam logic [V_W-1:0] CHAR_OFFSET = 7'd63;
    localparam logic [V_W-1:0] LONG_MARK   = 7'd126;
    localparam logic [V_W-1:0] SHORT_MAX   = 7'd62;
    localparam logic [V_W-1:0] ROUND_PAD   = 7'd5;
    localparam logic [2:0]     SHORT_HDR_LEN = 3'd1;
    localparam logic [2:0]     LONG_HDR_LEN  = 3'd4;
    localparam logic [WORD_W-1:0] WORD_MSB_MASK = 6'b100000;

    typedef struct packed {
        logic clear;     // clearing pass: write zero, advance sweep counter
        logic capture;   // take the input item
        logic mul;       // x*(x-1)
        logic div;       // split into word and bit
        logic pos;       // resolve cursor / address, issue RAM read
        logic mem;       // RAM data back: modify-write, form result
        logic load_out;  // move result into the output register
    } t_g6e_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } t_g6e_sts;

    // floor(s/6) for any 13-bit s: (s>>1)/3 via reciprocal 2731/8192
    function automatic logic [Q_W-1:0] div6(input logic [SUM_W-1:0] s);
        logic [23:0] p;
        p = 24'(s[SUM_W-1:1]) * 24'd2731;
        return p[23:13];
    endfunction

endpackage

@@ src/g6e_ram.sv @@
module g6e_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 336,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/g6e_ctrl.sv @@
module g6e_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  g6e_pkg::t_g6e_sts   i_sts,
    output g6e_pkg::t_g6e_cmd   o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_POS   = 3'd4;
    localparam logic [2:0] S_MEM   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_POS;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = S_MEM;
            end
            S_MEM: begin
                o_cmd.mem = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ src/g6e_datapath.sv @@
module g6e_datapath #(
    parameter int MAX_ORDER = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  g6e_pkg::t_g6e_cmd                   i_cmd,
    output g6e_pkg::t_g6e_sts                   o_sts,
    input  logic                                i_cfg_we,
    input  logic [g6e_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [g6e_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_op,
    input  logic [g6e_pkg::V_W-1:0]             i_vertex_a,
    input  logic [g6e_pkg::V_W-1:0]             i_vertex_b,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [g6e_pkg::V_W-1:0]             o_out_char,
    output logic                                o_out_last,
    output logic                                o_out_bad
);

    localparam int TRI_BITS   = (MAX_ORDER * (MAX_ORDER - 1)) / 2;
    localparam int WORD_DEPTH = (TRI_BITS + 5) / 6;
    localparam int ADDR_W     = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
    localparam int CUR_W      = $clog2(WORD_DEPTH + 4);
    localparam int CMP_W      = (CUR_W > 12) ? CUR_W : 12;
    localparam int N_CAP      = (MAX_ORDER < 127) ? MAX_ORDER : 127;

    localparam logic [1:0] HDR_POS_MARK = 2'd0;
    localparam logic [1:0] HDR_POS_HIGH = 2'd1;
    localparam logic [1:0] HDR_POS_MID  = 2'd2;
    localparam logic [1:0] HDR_POS_LOW  = 2'd3;

    // configuration
    logic [g6e_pkg::V_W-1:0] r_graph_order;
    logic                    r_vertex_base;

    // item context
    logic                          r_op;
    logic                          r_bad;
    logic [g6e_pkg::V_W-1:0]       r_n;
    logic [g6e_pkg::V_W-1:0]       r_u;
    logic [g6e_pkg::V_W-1:0]       r_v;
    logic [g6e_pkg::PROD_W-1:0]    r_prod;
    logic [g6e_pkg::Q_W-1:0]       r_q;
    logic [2:0]                    r_r;
    logic [ADDR_W-1:0]             r_addr;
    logic                          r_word_ok;
    logic                          r_hdr;
    logic                          r_last;
    logic [CUR_W-1:0]              r_c;
    logic [g6e_pkg::V_W-1:0]       r_hdr_char;
    logic [g6e_pkg::V_W-1:0]       r_res_char;
    logic                          r_res_last;
    logic                          r_res_bad;

    // persistent state
    logic [CUR_W-1:0]              r_cur;
    logic [ADDR_W-1:0]             r_clr_cnt;

    // output register
    logic                          r_out_valid;
    logic [g6e_pkg::V_W-1:0]       r_out_char;
    logic                          r_out_last;
    logic                          r_out_bad;

    // capture stage
    logic [g6e_pkg::V_W-1:0] eff_order;
    logic [g6e_pkg::V_W-1:0] base_ext;
    logic [g6e_pkg::V_W-1:0] a_reb;
    logic [g6e_pkg::V_W-1:0] b_reb;
    logic                    edge_bad;

    assign base_ext = {{(g6e_pkg::V_W-1){1'b0}}, r_vertex_base};
    assign a_reb    = i_vertex_a - base_ext;
    assign b_reb    = i_vertex_b - base_ext;

    always_comb begin
        if (r_graph_order == '0) begin
            eff_order = g6e_pkg::V_W'(1);
        end else if (int'(r_graph_order) > MAX_ORDER) begin
            eff_order = g6e_pkg::V_W'(N_CAP);
        end else begin
            eff_order = r_graph_order;
        end
    end

    assign edge_bad = (i_vertex_a < base_ext) || (i_vertex_b < base_ext) ||
                      (a_reb >= eff_order) || (b_reb >= eff_order) || (a_reb == b_reb);

    // shared multiply / divide-by-6 unit
    logic [g6e_pkg::V_W-1:0]   mul_x;
    logic [g6e_pkg::V_W-1:0]   mul_xm1;
    logic [g6e_pkg::V_W-1:0]   addend;
    logic [g6e_pkg::SUM_W-1:0] sum;
    logic [g6e_pkg::Q_W-1:0]   quot;
    logic [2:0]                rem;

    assign mul_x   = (r_op == g6e_pkg::OP_READ) ? r_n : r_v;
    assign mul_xm1 = mul_x - g6e_pkg::V_W'(1);
    assign addend  = (r_op == g6e_pkg::OP_READ) ? g6e_pkg::ROUND_PAD : r_u;
    assign sum     = g6e_pkg::SUM_W'(r_prod[g6e_pkg::PROD_W-1:1]) +
                     g6e_pkg::SUM_W'(addend);
    assign quot    = g6e_pkg::div6(sum);
    assign rem     = 3'(sum - g6e_pkg::SUM_W'(quot) * g6e_pkg::SUM_W'(6));

    // position stage
    logic [2:0]              hdr_len;
    logic [CMP_W-1:0]        total;
    logic [CUR_W-1:0]        cur_sel;
    logic [CUR_W-1:0]        word_ofs;
    logic [ADDR_W-1:0]       pos_addr;
    logic                    pos_ok;
    logic [g6e_pkg::V_W-1:0] hdr_char;

    assign hdr_len  = (r_n > g6e_pkg::SHORT_MAX) ? g6e_pkg::LONG_HDR_LEN
                                                 : g6e_pkg::SHORT_HDR_LEN;
    assign total    = CMP_W'(hdr_len) + CMP_W'(r_q);
    // cursor at or past the end (order lowered) restarts at the header
    assign cur_sel  = (CMP_W'(r_cur) >= total) ? '0 : r_cur;
    assign word_ofs = cur_sel - CUR_W'(hdr_len);

    always_comb begin
        if (r_op == g6e_pkg::OP_READ) begin
            pos_addr = ADDR_W'(word_ofs);
            pos_ok   = int'(word_ofs) < WORD_DEPTH;
        end else begin
            pos_addr = ADDR_W'(r_q);
            pos_ok   = int'(r_q) < WORD_DEPTH;
        end
    end

    always_comb begin
        if (r_n <= g6e_pkg::SHORT_MAX) begin
            hdr_char = r_n + g6e_pkg::CHAR_OFFSET;
        end else begin
            unique case (cur_sel[1:0])
                HDR_POS_MARK: hdr_char = g6e_pkg::LONG_MARK;
                HDR_POS_HIGH: hdr_char = g6e_pkg::CHAR_OFFSET;
                HDR_POS_MID:  hdr_char = g6e_pkg::CHAR_OFFSET +
                                         {{(g6e_pkg::V_W-1){1'b0}}, r_n[6]};
                HDR_POS_LOW:  hdr_char = g6e_pkg::CHAR_OFFSET + {1'b0, r_n[5:0]};
                default:      hdr_char = g6e_pkg::CHAR_OFFSET;
            endcase
        end
    end

    // memory
    logic [g6e_pkg::WORD_W-1:0] rdata;
    logic [g6e_pkg::WORD_W-1:0] bit_mask;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [g6e_pkg::WORD_W-1:0] mem_wdata;
    logic                       item_write;

    assign bit_mask   = g6e_pkg::WORD_MSB_MASK >> r_r;
    assign item_write = (r_op == g6e_pkg::OP_READ) ? (!r_hdr && r_word_ok)
                                                   : (!r_bad && r_word_ok);
    assign mem_we     = i_cmd.clear || (i_cmd.mem && item_write);
    assign mem_waddr  = i_cmd.clear ? r_clr_cnt : r_addr;
    assign mem_wdata  = (i_cmd.clear || (r_op == g6e_pkg::OP_READ)) ? '0
                                                                   : (rdata | bit_mask);

    g6e_ram #(
        .WIDTH (g6e_pkg::WORD_W),
        .DEPTH (WORD_DEPTH)
    ) u_words (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.pos),
        .i_raddr (pos_addr),
        .o_rdata (rdata)
    );

    // datapath registers (no reset needed)
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_n   <= eff_order;
            r_bad <= edge_bad;
            r_u   <= (a_reb < b_reb) ? a_reb : b_reb;
            r_v   <= (a_reb < b_reb) ? b_reb : a_reb;
        end
        if (i_cmd.mul) begin
            r_prod <= g6e_pkg::PROD_W'(mul_x) * g6e_pkg::PROD_W'(mul_xm1);
        end
        if (i_cmd.div) begin
            r_q <= quot;
            r_r <= rem;
        end
        if (i_cmd.pos) begin
            r_addr     <= pos_addr;
            r_word_ok  <= pos_ok;
            r_c        <= cur_sel;
            r_hdr      <= CMP_W'(cur_sel) < CMP_W'(hdr_len);
            r_last     <= (CMP_W'(cur_sel) + CMP_W'(1)) == total;
            r_hdr_char <= hdr_char;
        end
        if (i_cmd.mem) begin
            if (r_op == g6e_pkg::OP_READ) begin
                r_res_bad  <= 1'b0;
                r_res_last <= r_last;
                if (r_hdr) begin
                    r_res_char <= r_hdr_char;
                end else begin
                    r_res_char <= g6e_pkg::CHAR_OFFSET +
                                  (r_word_ok ? {1'b0, rdata} : '0);
                end
            end else begin
                r_res_bad  <= r_bad;
                r_res_last <= 1'b0;
                r_res_char <= '0;
            end
        end
        if (i_cmd.load_out) begin
            r_out_char <= r_res_char;
            r_out_last <= r_res_last;
            r_out_bad  <= r_res_bad;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_graph_order <= g6e_pkg::ORDER_RESET;
            r_vertex_base <= 1'b0;
            r_cur         <= '0;
            r_clr_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    g6e_pkg::CFG_GRAPH_ORDER: r_graph_order <= i_cfg_data;
                    g6e_pkg::CFG_VERTEX_BASE: r_vertex_base <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (i_cmd.mem && (r_op == g6e_pkg::OP_READ)) begin
                r_cur <= r_last ? '0 : (r_c + CUR_W'(1));
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_done = (r_clr_cnt == ADDR_W'(WORD_DEPTH - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;
    assign o_out_bad   = r_out_bad;

endmodule

@@ src/graph6_adjacency_encoder.sv @@
// graph6 encoder for a simple undirected graph of up to MAX_ORDER vertices.
// Send edge transfers (tuser = 0, two vertex numbers in tdata) to set bits of
// the upper-triangular adjacency string, then read transfers (tuser = 1) to
// pull the encoding out one character per transfer: the order header, then
// one character per 6-bit word; tlast marks the final character, and each
// word is cleared as it is read so a full read-out leaves the store empty.
// Every input transfer gives exactly one output transfer. Edge transfers
// return a zero character with tuser set when the edge was a self-loop or
// out of range (such edges change nothing). Items are processed one at a
// time by a six-step sequence (capture, multiply, divide by six, address,
// RAM read-modify-write, output load); the word RAM has one write port and a
// registered read. The next item is taken once the last has passed the output
// step, which waits while the output register holds an untaken result. One
// result can sit in the output register while the next item is taken. After
// reset a clearing pass zeros (MAX_ORDER*(MAX_ORDER-1)/2+5)/6 RAM words (336
// at the default), one per cycle, with s_axis_tready low; configuration writes
// are taken at any time but should only be issued while the block is idle.
module graph6_adjacency_encoder #(
    parameter int MAX_ORDER = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration: index 0 graph_order[6:0], index 1 vertex_base[0]
    input  logic                               i_cfg_we,
    input  logic [g6e_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [g6e_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [6:0] vertex_a, [13:7] vertex_b, [15:14] zero
    input  logic        s_axis_tuser,   // [0] operation: 0 set edge, 1 read char

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic        m_axis_tlast,   // last_char
    output logic        m_axis_tuser    // [0] bad_edge
);

    g6e_pkg::t_g6e_cmd cmd;
    g6e_pkg::t_g6e_sts sts;
    logic [g6e_pkg::V_W-1:0] out_char;

    g6e_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    g6e_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_vertex_a  (s_axis_tdata[6:0]),
        .i_vertex_b  (s_axis_tdata[13:7]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (out_char),
        .o_out_last  (m_axis_tlast),
        .o_out_bad   (m_axis_tuser)
    );

    // pad the character to a whole byte
    assign m_axis_tdata = {1'b0, out_char};

endmodule

@@ src/g6e_checker.sv @@
module g6e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // reset starts the clearing pass, so no item is taken right after it
    a_ready_low_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // one item in flight: an accepted item blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted back to back");

    // a flagged edge never carries a character
    a_bad_has_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0) && !m_axis_tlast)
        else $error("bad edge result with character or last");

    // the final character is printable graph6
    a_last_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata >= 8'd63) &&
                                            (m_axis_tdata <= 8'd126))
        else $error("last character out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer dropped or changed while stalled");

endmodule

bind graph6_adjacency_encoder g6e_checker u_g6e_checker (.*);

@@ tb/tb_graph6_adjacency_encoder.sv @@
module tb_graph6_adjacency_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ORDER  = 64;
    localparam int WORD_DEPTH = (MAX_ORDER * (MAX_ORDER - 1) / 2 + 5) / 6;
    localparam int RAND_ITEMS = 1850;
    localparam int HOLD_CYCLES = 500;   // long receiver hold-off, fills the block
    localparam int WATCHDOG    = 5000;  // cycles without any transfer

    // one input item: operation plus two raw vertex numbers
    typedef struct packed {
        logic       op;
        logic [6:0] va;
        logic [6:0] vb;
    } t_g6_item;

    // one output item
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       bad;
    } t_g6_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [g6e_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [g6e_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = g6e_pkg::OP_EDGE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    graph6_adjacency_encoder #(.MAX_ORDER(MAX_ORDER)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [6:0] vertex_a, [13:7] vertex_b, [15:14] zero
        .s_axis_tuser  (s_axis_tuser),   // [0] operation
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [6:0] out_char, [7] zero
        .m_axis_tlast  (m_axis_tlast),   // last_char
        .m_axis_tuser  (m_axis_tuser)    // [0] bad_edge
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: mirror of the word store, read position and the
    // two registers. Registers only change while the block is idle.
    // ---------------------------------------------------------------
    logic [5:0]  adj_words [WORD_DEPTH] = '{default: '0};
    int unsigned read_pos  = 0;
    logic [6:0]  cfg_order = g6e_pkg::ORDER_RESET;
    logic        cfg_base  = 1'b0;

    t_g6_item item_queue [$];       // items waiting for the driver
    t_g6_char expected_chars [$];   // predicted output transfers, oldest first

    int items_pushed   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int n_edges = 0, n_bad = 0, n_chars = 0, n_last = 0, n_settings = 0;

    // order 0 acts as 1, anything past MAX_ORDER acts as MAX_ORDER
    function automatic int unsigned clamp_order(input logic [6:0] order);
        if (order == 0)
            return 1;
        if (order > MAX_ORDER)
            return MAX_ORDER;
        return order;
    endfunction

    function automatic int unsigned header_len(input int unsigned n);
        return (n > g6e_pkg::SHORT_MAX) ? 4 : 1;
    endfunction

    // header characters plus one character per 6-bit word
    function automatic int unsigned enc_length(input int unsigned n);
        return header_len(n) + (n * (n - 1) / 2 + 5) / 6;
    endfunction

    // Apply one item to the mirror and return the character it yields.
    function automatic t_g6_char encode_item(input t_g6_item it);
        t_g6_char    r;
        int unsigned n, a, b, u, v, k, w, h, total;
        r = '0;
        n = clamp_order(cfg_order);
        if (it.op == g6e_pkg::OP_EDGE) begin
            a = it.va;
            b = it.vb;
            if (a < cfg_base || b < cfg_base) begin
                r.bad = 1'b1;
            end else begin
                a = a - cfg_base;
                b = b - cfg_base;
                if (a >= n || b >= n || a == b) begin
                    r.bad = 1'b1;
                end else begin
                    u = (a < b) ? a : b;
                    v = (a < b) ? b : a;
                    k = v * (v - 1) / 2 + u;
                    w = k / 6;
                    // bit k sits MSB-first inside its word
                    adj_words[w][5 - k % 6] = 1'b1;
                end
            end
        end else begin
            h = header_len(n);
            total = enc_length(n);
            // order lowered under a running read-out: start over at the header
            if (read_pos >= total)
                read_pos = 0;
            if (read_pos < h) begin
                if (n <= g6e_pkg::SHORT_MAX) begin
                    r.ch = 7'(n + g6e_pkg::CHAR_OFFSET);
                end else begin
                    case (read_pos)
                        0: r.ch = g6e_pkg::LONG_MARK;
                        1: r.ch = 7'(((n >> 12) & 63) + g6e_pkg::CHAR_OFFSET);
                        2: r.ch = 7'(((n >> 6) & 63) + g6e_pkg::CHAR_OFFSET);
                        default: r.ch = 7'((n & 63) + g6e_pkg::CHAR_OFFSET);
                    endcase
                end
            end else begin
                // words are cleared as they are read
                w = read_pos - h;
                r.ch = 7'(adj_words[w] + g6e_pkg::CHAR_OFFSET);
                adj_words[w] = '0;
            end
            if (read_pos + 1 == total) begin
                r.last = 1'b1;
                read_pos = 0;
            end else begin
                read_pos++;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driver: bursts of random length with random gaps. Prediction is
    // made at the edge where the input transfer happens.
    // ---------------------------------------------------------------
    t_g6_item cur_item;
    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge i_clk) begin : tx
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= g6e_pkg::OP_EDGE;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_chars.push_back(encode_item(cur_item));
                items_accepted++;
            end
            // free to present a new item (or nothing) only when not holding one
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (item_queue.size() > 0) begin
                    cur_item = item_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, cur_item.vb, cur_item.va};
                    s_axis_tuser  <= cur_item.op;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        // one burst in three runs straight into the next
                        gap_left = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each output transfer against the oldest
    // prediction; tready follows its own pattern plus one long hold-off.
    // ---------------------------------------------------------------
    int  rx_mode   = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  held_off  = 1'b0;

    always @(posedge i_clk) begin : rx
        t_g6_char want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_chars.size() == 0) begin
                    $error("output transfer with nothing expected: out_char %0d",
                           m_axis_tdata[6:0]);
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata[6:0] !== want.ch) begin
                        $error("out_char mismatch: expected %0d, actual %0d",
                               want.ch, m_axis_tdata[6:0]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_char mismatch: expected %0d, actual %0d",
                               want.last, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.bad) begin
                        $error("bad_edge mismatch: expected %0d, actual %0d",
                               want.bad, m_axis_tuser);
                        fail_count++;
                    end
                    n_bad  += want.bad;
                    n_last += want.last;
                end
            end
            // one long hold-off while the sender keeps offering items
            if (!held_off && results_seen >= 150) begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 150);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;                   // always ready
                    1: m_axis_tready <= 1'($urandom % 2);       // coin toss
                    default: m_axis_tready <= ($urandom % 4 == 0); // mostly stalled
                endcase
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    // Covers the clearing pass after reset and the long hold-off.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == WATCHDOG) begin
                $display("tb_graph6_adjacency_encoder: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic add_item(input logic op, input logic [6:0] a, input logic [6:0] b);
        t_g6_item it;
        it.op = op;
        it.va = a;
        it.vb = b;
        item_queue.push_back(it);
        items_pushed++;
        if (op == g6e_pkg::OP_EDGE)
            n_edges++;
        else
            n_chars++;
    endtask

    // register write; only called while the block is idle
    task automatic set_reg(input logic [g6e_pkg::CFG_IDX_W-1:0] idx,
                           input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == g6e_pkg::CFG_GRAPH_ORDER)
            cfg_order = val;
        else
            cfg_base = val[0];
        n_settings++;
    endtask

    // wait for every item to go in and every result to come back
    task automatic settle();
        while (!(items_accepted == items_pushed && results_seen == items_pushed))
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_reads(input int cnt);
        for (int i = 0; i < cnt; i++)
            add_item(g6e_pkg::OP_READ, 7'($urandom), 7'($urandom));
    endtask

    // edge between two distinct in-range vertices, or a rejected one if none exist
    task automatic add_good_edge(input int unsigned n);
        int unsigned a, b;
        if (n < 2) begin
            add_item(g6e_pkg::OP_EDGE, 7'(cfg_base), 7'(cfg_base));
        end else begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 2);
            if (b >= a)
                b++;
            add_item(g6e_pkg::OP_EDGE, 7'(a + cfg_base), 7'(b + cfg_base));
        end
    endtask

    // mostly rejected edges: raw noise, self-loops, past the order, below base
    task automatic add_noise_edge(input int unsigned n);
        logic [6:0] x;
        x = 7'($urandom);
        case ($urandom % 4)
            0: add_item(g6e_pkg::OP_EDGE, x, 7'($urandom));
            1: add_item(g6e_pkg::OP_EDGE, x, x);
            2: add_item(g6e_pkg::OP_EDGE, 7'(n + cfg_base), 7'($urandom_range(0, 127)));
            default: add_item(g6e_pkg::OP_EDGE, 7'($urandom_range(0, 127)), 7'(0));
        endcase
    endtask

    // one graph: new registers, random edges, then a read-out of the encoding
    task automatic random_graph(input logic [6:0] order);
        int unsigned n, m, len;
        settle();
        set_reg(g6e_pkg::CFG_GRAPH_ORDER, order);
        // upper data bits are don't-care for the base register
        set_reg(g6e_pkg::CFG_VERTEX_BASE, 7'($urandom));
        n = clamp_order(order);
        m = (n < 2) ? $urandom_range(0, 4) : $urandom_range(1, (3 * n > 48) ? 48 : 3 * n);
        if ($urandom % 6 == 0)
            add_reads(1);   // stray read before the graph is built
        for (int i = 0; i < m; i++) begin
            if ($urandom % 8 == 0)
                add_noise_edge(n);
            else
                add_good_edge(n);
        end
        len = enc_length(n);
        if ($urandom % 8 == 0)
            len = $urandom_range(1, len);   // leave a read-out unfinished
        for (int i = 0; i < len; i++) begin
            add_reads(1);
            if ($urandom % 16 == 0)
                add_good_edge(n);           // edge lands mid read-out
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings (order 64, base 0). Corner vertices, rejects,
        // and the four-character long header only.
        add_item(g6e_pkg::OP_EDGE, 7'd0, 7'd1);
        add_item(g6e_pkg::OP_EDGE, 7'd63, 7'd62);   // last bit of the last word
        add_item(g6e_pkg::OP_EDGE, 7'd64, 7'd0);    // past the order
        add_item(g6e_pkg::OP_EDGE, 7'd5, 7'd5);     // self-loop
        add_item(g6e_pkg::OP_EDGE, 7'd127, 7'd127);
        add_reads(4);
        settle();

        // order 5, base 1; read position now past the end, so it restarts
        set_reg(g6e_pkg::CFG_GRAPH_ORDER, 7'd5);
        set_reg(g6e_pkg::CFG_VERTEX_BASE, 7'd1);
        add_item(g6e_pkg::OP_EDGE, 7'd1, 7'd2);
        add_item(g6e_pkg::OP_EDGE, 7'd5, 7'd4);
        add_item(g6e_pkg::OP_EDGE, 7'd0, 7'd3);     // below base
        add_item(g6e_pkg::OP_EDGE, 7'd6, 7'd1);     // past the order after rebasing
        add_item(g6e_pkg::OP_EDGE, 7'd3, 7'd3);
        add_item(g6e_pkg::OP_EDGE, 7'd2, 7'd1);     // repeated edge
        add_reads(4);                               // full encoding, then header again
        settle();

        // order zero acts as one: header only, every character final
        set_reg(g6e_pkg::CFG_GRAPH_ORDER, 7'd0);
        add_reads(2);
        settle();

        // order past the maximum acts as the maximum
        set_reg(g6e_pkg::CFG_GRAPH_ORDER, 7'd127);
        set_reg(g6e_pkg::CFG_VERTEX_BASE, 7'd0);
        add_reads(4);

        // Random graphs: the order extremes once each, then mostly small graphs
        random_graph(7'd1);
        random_graph(7'd2);
        random_graph(7'd62);
        random_graph(7'd63);
        random_graph(7'd64);
        while (items_pushed < RAND_ITEMS) begin
            case ($urandom % 10)
                0: random_graph(7'd0);
                1: random_graph(7'($urandom_range(17, 40)));
                default: random_graph(7'($urandom_range(2, 16)));
            endcase
        end
        settle();
        repeat (20) @(posedge i_clk);

        if (expected_chars.size() != 0) begin
            $error("%0d expected characters never arrived", expected_chars.size());
            fail_count++;
        end
        $display("Covered %0d edge items (%0d rejected) and %0d character reads",
                 n_edges, n_bad, n_chars);
        $display("over %0d register writes, %0d final characters, %0d failures",
                 n_settings, n_last, fail_count);
        if (fail_count == 0)
            $display("tb_graph6_adjacency_encoder: PASS");
        else
            $display("tb_graph6_adjacency_encoder: FAIL");
        $finish;
    end

endmodule
